// File: hw/rtl/magnetometer_heading_top_macros.svh
// Assertion macros shared by the magnetometer heading RTL.
`ifndef MAGNETOMETER_HEADING_TOP_MACROS_SVH
`define MAGNETOMETER_HEADING_TOP_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define MH_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequence holds in the same cycle as its condition.
`define MH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/mh_pkg.sv
// Package with the widths, constants, arctangent table and payload type of the heading pipeline.
package mh_pkg;

   localparam int IN_W          = 16;
   localparam int OUT_W         = 16;
   localparam int FRAC_SHIFT    = 20;
   localparam int XY_W          = 40;
   localparam int Z_W           = 25;
   localparam int SUM_W         = 26;
   localparam int RND_SHIFT     = 8;
   localparam int R_W           = SUM_W - RND_SHIFT;
   localparam int ANG_LEN       = 24;
   localparam int CORDIC_STAGES = 16;
   localparam int NUM_STAGES    = (CORDIC_STAGES < ANG_LEN) ? CORDIC_STAGES : ANG_LEN;

   localparam logic signed [Z_W-1:0]   QUARTER_FINE = Z_W'(2949120);
   localparam logic signed [IN_W-1:0]  DECL_LIMIT   = IN_W'(23040);
   localparam logic signed [R_W-1:0]   FULL_TURN    = R_W'(46080);
   localparam logic [OUT_W-1:0]        HEADING_MAX  = OUT_W'(46079);
   localparam logic [RND_SHIFT-1:0]    RND_HALF     = 8'h80;

   // atan(2^-i) in degrees, scaled by 2^15
   function automatic logic signed [Z_W-1:0] ang_entry(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:  val = Z_W'(1474560);
         1:  val = Z_W'(870484);
         2:  val = Z_W'(459940);
         3:  val = Z_W'(233473);
         4:  val = Z_W'(117189);
         5:  val = Z_W'(58652);
         6:  val = Z_W'(29333);
         7:  val = Z_W'(14667);
         8:  val = Z_W'(7334);
         9:  val = Z_W'(3667);
         10: val = Z_W'(1833);
         11: val = Z_W'(917);
         12: val = Z_W'(458);
         13: val = Z_W'(229);
         14: val = Z_W'(115);
         15: val = Z_W'(57);
         16: val = Z_W'(29);
         17: val = Z_W'(14);
         18: val = Z_W'(7);
         19: val = Z_W'(4);
         20: val = Z_W'(2);
         21: val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

   typedef struct packed {
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } mh_vec_type;

endpackage

// File: hw/rtl/magnetometer_heading_top.sv
// Top level of the compass heading pipeline: magnetometer X/Y in, heading out.
//
//   group   dir  handshake            payload
//   req_    in   req_tvalid/tready    tdata[15:0] field_x, [31:16] field_y
//   rsp_    out  rsp_tvalid/tready    tdata[15:0] heading (1/128 degree)
//   csr_    in   csr_wr_en            csr_wr_data declination (1/128 degree)
//
// Throughput: one request per cycle while the response side is not stalled.
// Pipeline: one input fold stage, one register per CORDIC micro-rotation and
// one declination/round/wrap stage.
// Reset clears all valid bits and the declination register; no clearing pass.
// Stalls: each stage holds its item while the stage after it is full and
// stalled, so empty slots fill up and a request is taken while any slot is free.
`include "magnetometer_heading_top_macros.svh"

module magnetometer_heading_top (
   input  logic        clock,
   input  logic        reset,
   // csr: declination, signed
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] field_x, [31:16] field_y
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [15:0] heading
);

   logic               pre_valid;
   logic               pre_ready;
   mh_pkg::mh_vec_type pre_vec;
   logic               cor_valid;
   logic               cor_ready;
   mh_pkg::mh_vec_type cor_vec;

   // fold the vector into the right half plane
   mh_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .field_x   ($signed(req_tdata[15:0])),
      .field_y   ($signed(req_tdata[31:16])),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_vec   (pre_vec)
   );

   // drive y to zero while accumulating the angle
   mh_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_vec    (pre_vec),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_vec   (cor_vec)
   );

   // add declination, round and wrap; the output register sits here
   mh_post u_post (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data ($signed(csr_wr_data)),
      .in_valid    (cor_valid),
      .in_ready    (cor_ready),
      .in_vec      (cor_vec),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_heading (rsp_tdata)
   );

   `MH_ASSERT_IMPLY(a_top_heading_range, clock, reset, rsp_tvalid, rsp_tdata <= mh_pkg::HEADING_MAX, "heading beyond one turn")

endmodule

// File: hw/rtl/mh_prerot.sv
// Input stage: scale the X/Y pair and fold the left half plane into x >= 0.
`include "magnetometer_heading_top_macros.svh"

module mh_prerot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [mh_pkg::IN_W-1:0] field_x,
   input  logic signed [mh_pkg::IN_W-1:0] field_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output mh_pkg::mh_vec_type            out_vec
);

   localparam int EXT_W = mh_pkg::XY_W - mh_pkg::IN_W - mh_pkg::FRAC_SHIFT;

   logic                           valid_ff;
   mh_pkg::mh_vec_type             vec_ff;
   mh_pkg::mh_vec_type             vec_in;
   logic signed [mh_pkg::XY_W-1:0] x_sc;
   logic signed [mh_pkg::XY_W-1:0] y_sc;

   assign x_sc = {{EXT_W{field_x[mh_pkg::IN_W-1]}}, field_x, {mh_pkg::FRAC_SHIFT{1'b0}}};
   assign y_sc = {{EXT_W{field_y[mh_pkg::IN_W-1]}}, field_y, {mh_pkg::FRAC_SHIFT{1'b0}}};

   always_comb begin
      vec_in.zero = (field_x == '0) && (field_y == '0);
      if (vec_in.zero) begin
         vec_in.x = '0;
         vec_in.y = '0;
         vec_in.z = '0;
      end else if (x_sc < 0) begin
         if (y_sc >= 0) begin
            vec_in.x = y_sc;
            vec_in.y = -x_sc;
            vec_in.z = mh_pkg::QUARTER_FINE;
         end else begin
            vec_in.x = -y_sc;
            vec_in.y = x_sc;
            vec_in.z = -mh_pkg::QUARTER_FINE;
         end
      end else begin
         vec_in.x = x_sc;
         vec_in.y = y_sc;
         vec_in.z = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   `MH_ASSERT_IMPLY(a_prerot_x_nonneg, clock, reset, valid_ff, vec_ff.x >= 0, "folded x is negative")

endmodule

// File: hw/rtl/mh_cordic.sv
// CORDIC vectoring pipeline: one register stage per micro-rotation.
`include "magnetometer_heading_top_macros.svh"

module mh_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mh_pkg::mh_vec_type in_vec,
   output logic               out_valid,
   input  logic               out_ready,
   output mh_pkg::mh_vec_type out_vec
);

   localparam int LAST = mh_pkg::NUM_STAGES - 1;

   logic               valid_ff [mh_pkg::NUM_STAGES];
   mh_pkg::mh_vec_type vec_ff   [mh_pkg::NUM_STAGES];
   logic               stg_ready[mh_pkg::NUM_STAGES];

   for (genvar k = 0; k < mh_pkg::NUM_STAGES; k++) begin : g_stage
      logic                           prev_valid;
      mh_pkg::mh_vec_type             prev_vec;
      logic                           next_ready;
      logic signed [mh_pkg::XY_W-1:0] xs;
      logic signed [mh_pkg::XY_W-1:0] ys;
      mh_pkg::mh_vec_type             vec_in;

      if (k == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_vec   = in_vec;
      end else begin : g_body
         assign prev_valid = valid_ff[k-1];
         assign prev_vec   = vec_ff[k-1];
      end

      if (k == LAST) begin : g_tail
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = stg_ready[k+1];
      end

      assign stg_ready[k] = !valid_ff[k] || next_ready;

      assign xs = prev_vec.x >>> k;
      assign ys = prev_vec.y >>> k;

      // rotate clockwise while y is above the axis
      always_comb begin
         vec_in.zero = prev_vec.zero;
         if (prev_vec.y > 0) begin
            vec_in.x = prev_vec.x + ys;
            vec_in.y = prev_vec.y - xs;
            vec_in.z = prev_vec.z + mh_pkg::ang_entry(k);
         end else begin
            vec_in.x = prev_vec.x - ys;
            vec_in.y = prev_vec.y + xs;
            vec_in.z = prev_vec.z - mh_pkg::ang_entry(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stg_ready[k]) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_ready[k] && prev_valid) begin
            vec_ff[k] <= vec_in;
         end
      end
   end

   assign in_ready  = stg_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_vec   = vec_ff[LAST];

   `MH_ASSERT_IMPLY(a_cordic_zero_stays, clock, reset, valid_ff[LAST] && vec_ff[LAST].zero, (vec_ff[LAST].x == 0) && (vec_ff[LAST].y == 0), "zero vector picked up magnitude")

endmodule

// File: hw/rtl/mh_post.sv
// Output stage: add declination, round to 1/128 degree, wrap into one turn; holds the declination register.
`include "magnetometer_heading_top_macros.svh"

module mh_post (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic signed [mh_pkg::IN_W-1:0]  csr_wr_data,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  mh_pkg::mh_vec_type             in_vec,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [mh_pkg::OUT_W-1:0]        out_heading
);

   logic                             valid_ff;
   logic [mh_pkg::OUT_W-1:0]         heading_ff;
   logic [mh_pkg::OUT_W-1:0]         heading_in;
   logic signed [mh_pkg::IN_W-1:0]   decl_ff;
   logic signed [mh_pkg::IN_W-1:0]   decl_in;
   logic signed [mh_pkg::Z_W-1:0]    angle;
   logic signed [mh_pkg::SUM_W-1:0]  sum;
   logic signed [mh_pkg::R_W-1:0]    rnd;
   logic signed [mh_pkg::R_W-1:0]    wrapped;

   // saturate at write time
   always_comb begin
      if (csr_wr_data > mh_pkg::DECL_LIMIT) begin
         decl_in = mh_pkg::DECL_LIMIT;
      end else if (csr_wr_data < -mh_pkg::DECL_LIMIT) begin
         decl_in = -mh_pkg::DECL_LIMIT;
      end else begin
         decl_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr_wr_en) begin
         decl_ff <= decl_in;
      end
   end

   // declination*256 plus the rounding half folds into one concatenated addend
   assign angle = in_vec.zero ? '0 : in_vec.z;
   assign sum   = mh_pkg::SUM_W'(angle) + mh_pkg::SUM_W'($signed({decl_ff, mh_pkg::RND_HALF}));
   assign rnd   = sum[mh_pkg::SUM_W-1:mh_pkg::RND_SHIFT];

   always_comb begin
      if (rnd < 0) begin
         wrapped = rnd + mh_pkg::FULL_TURN;
      end else if (rnd >= mh_pkg::FULL_TURN) begin
         wrapped = rnd - mh_pkg::FULL_TURN;
      end else begin
         wrapped = rnd;
      end
   end

   assign heading_in = wrapped[mh_pkg::OUT_W-1:0];
   assign in_ready   = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         heading_ff <= heading_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_heading = heading_ff;

   `MH_ASSERT_ALWAYS(a_post_decl_range, clock, reset, (decl_ff <= mh_pkg::DECL_LIMIT) && (decl_ff >= -mh_pkg::DECL_LIMIT), "declination outside limits")

endmodule
